FILE: rtl/uvs_pkg.sv
// ----------------------------------------------------------------------------
// uvs_pkg
// shared types and constants for the bounded value set
// ----------------------------------------------------------------------------
package uvs_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int VAL_W        = 32;
    localparam int CNT_W        = 7;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_SEARCH = 2'd2;
    localparam logic [1:0] OP_RANGE  = 2'd3;

    localparam logic [VAL_W-1:0] KEY_FLIP = {1'b1, {(VAL_W-1){1'b0}}};

    // token that walks the cell chain
    typedef struct packed {
        logic             hit;
        logic             free_seen;
        logic             any;
        logic [VAL_W-1:0] kmin;
        logic [VAL_W-1:0] kmax;
    } tok_t;

    // commit command broadcast to every cell
    typedef struct packed {
        logic add_en;
        logic rem_en;
    } cmd_t;

endpackage

FILE: rtl/uvs_req_if.sv
// ----------------------------------------------------------------------------
// uvs_req_if
// request channel: operation and value
// ----------------------------------------------------------------------------
interface uvs_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         op;
    logic signed [31:0] elem;

    modport source (output valid, output op, output elem, input ready);
    modport sink   (input valid, input op, input elem, output ready);
endinterface

FILE: rtl/uvs_rsp_if.sv
// ----------------------------------------------------------------------------
// uvs_rsp_if
// response channel: status flags, span and element count
// ----------------------------------------------------------------------------
interface uvs_rsp_if;
    logic        valid;
    logic        ready;
    logic        ok;
    logic        full_res;
    logic [31:0] span;
    logic        empty_res;
    logic [6:0]  count;

    modport source (output valid, output ok, output full_res, output span,
                    output empty_res, output count, input ready);
    modport sink   (input valid, input ok, input full_res, input span,
                    input empty_res, input count, output ready);
endinterface

FILE: rtl/uvs_cell.sv
// ----------------------------------------------------------------------------
// uvs_cell
// one slot of the set: holds a value, compares it and forwards the token
// ----------------------------------------------------------------------------
module uvs_cell
    import uvs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [VAL_W-1:0] elem,
    input  cmd_t             cmd,
    input  logic             vld_in,
    input  tok_t             tok_in,
    output logic             vld_out,
    output tok_t             tok_out,
    output logic             used
);

    logic [VAL_W-1:0] value_reg;
    logic             used_reg;
    logic             cand_reg;
    logic             vld_reg;
    tok_t             tok_reg;
    tok_t             tok_next;
    logic             match;
    logic [VAL_W-1:0] key;

    assign match = used_reg && (value_reg == elem);
    assign key   = value_reg ^ KEY_FLIP;

    always_comb
    begin
        tok_next           = tok_in;
        tok_next.hit       = tok_in.hit | match;
        tok_next.free_seen = tok_in.free_seen | ~used_reg;
        tok_next.any       = tok_in.any | used_reg;
        if (used_reg)
        begin
            if (!tok_in.any)
            begin
                tok_next.kmin = key;
                tok_next.kmax = key;
            end
            else
            begin
                if (key < tok_in.kmin)
                begin
                    tok_next.kmin = key;
                end
                if (key > tok_in.kmax)
                begin
                    tok_next.kmax = key;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
            cand_reg <= 1'b0;
            vld_reg  <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_in;
            if (vld_in)
            begin
                cand_reg <= ~used_reg & ~tok_in.free_seen;
            end
            if (cmd.add_en && cand_reg)
            begin
                used_reg <= 1'b1;
            end
            else if (cmd.rem_en && match)
            begin
                used_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (vld_in)
        begin
            tok_reg <= tok_next;
        end
        if (cmd.add_en && cand_reg)
        begin
            value_reg <= elem;
        end
    end

    assign vld_out = vld_reg;
    assign tok_out = tok_reg;
    assign used    = used_reg;

endmodule

FILE: rtl/unique_value_set_with_range_top.sv
// ----------------------------------------------------------------------------
// unique_value_set_with_range_top
// bounded set of distinct 32-bit signed values with add, remove, search and range
// ----------------------------------------------------------------------------
// The set lives in a row of CAPACITY cells, one value per cell. A request is
// taken only while the block is idle; its token then walks the row one cell per
// cycle, gathering match, first free slot and running minimum and maximum, and
// the add or remove is committed to the cells at the end, in the commit state.
// The response word is registered at the commit, and the next request is taken
// only once the block is back to idle after that commit. A finished response
// waits in an output register until taken, and while it waits the next request
// can walk the row but is not committed. Add goes to the lowest free cell; count
// reports the element count modulo 128.
// ----------------------------------------------------------------------------
module unique_value_set_with_range_top
    import uvs_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic  clk,
    input  logic  rst_n,
    uvs_req_if.sink   req,
    uvs_rsp_if.source rsp
);

    localparam int FILL_W = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_COMMIT} state_t;

    state_t            state_reg;
    logic [1:0]        op_reg;
    logic [VAL_W-1:0]  elem_reg;
    logic              launch_reg;
    tok_t              fin_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;

    logic              rsp_valid_reg;
    logic              ok_reg;
    logic              full_reg;
    logic [VAL_W-1:0]  span_reg;
    logic              empty_reg;
    logic [CNT_W-1:0]  count_reg;

    logic              ok_next;
    logic              full_next;
    logic [VAL_W-1:0]  span_next;
    logic [FILL_W+CNT_W-1:0] fill_ext;

    logic              accept;
    logic              commit_go;
    cmd_t              cmd;

    logic              vld_chain [CAPACITY+1];
    tok_t              tok_chain [CAPACITY+1];
    logic [CAPACITY-1:0] used_vec;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign commit_go = (state_reg == ST_COMMIT) && (!rsp_valid_reg || rsp.ready);

    assign vld_chain[0] = launch_reg;
    assign tok_chain[0] = '0;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        uvs_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .elem    (elem_reg),
            .cmd     (cmd),
            .vld_in  (vld_chain[i]),
            .tok_in  (tok_chain[i]),
            .vld_out (vld_chain[i+1]),
            .tok_out (tok_chain[i+1]),
            .used    (used_vec[i])
        );
    end

    always_comb
    begin
        ok_next    = 1'b0;
        full_next  = 1'b0;
        span_next  = '0;
        fill_next  = fill_reg;
        cmd.add_en = 1'b0;
        cmd.rem_en = 1'b0;
        case (op_reg)
            OP_ADD:
            begin
                ok_next   = ~fin_reg.hit & fin_reg.free_seen;
                full_next = ~fin_reg.hit & ~fin_reg.free_seen;
                if (ok_next)
                begin
                    fill_next = fill_reg + FILL_W'(1);
                end
                cmd.add_en = commit_go & ok_next;
            end
            OP_REMOVE:
            begin
                ok_next = fin_reg.hit;
                if (ok_next)
                begin
                    fill_next = fill_reg - FILL_W'(1);
                end
                cmd.rem_en = commit_go & ok_next;
            end
            OP_SEARCH:
            begin
                ok_next = fin_reg.hit;
            end
            OP_RANGE:
            begin
                ok_next = fin_reg.any;
                if (fin_reg.any)
                begin
                    span_next = fin_reg.kmax - fin_reg.kmin;
                end
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase
    end

    assign fill_ext = {{CNT_W{1'b0}}, fill_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            launch_reg    <= 1'b0;
            fill_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            launch_reg <= 1'b0;
            if (rsp_valid_reg && rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        launch_reg <= 1'b1;
                        state_reg  <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (vld_chain[CAPACITY])
                    begin
                        state_reg <= ST_COMMIT;
                    end
                end
                ST_COMMIT:
                begin
                    if (commit_go)
                    begin
                        fill_reg      <= fill_next;
                        rsp_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= req.op;
            elem_reg <= VAL_W'(req.elem);
        end
        if (vld_chain[CAPACITY])
        begin
            fin_reg <= tok_chain[CAPACITY];
        end
        if (commit_go)
        begin
            ok_reg    <= ok_next;
            full_reg  <= full_next;
            span_reg  <= span_next;
            empty_reg <= (fill_next == '0);
            count_reg <= fill_ext[CNT_W-1:0];
        end
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.ok        = ok_reg;
    assign rsp.full_res  = full_reg;
    assign rsp.span      = span_reg;
    assign rsp.empty_res = empty_reg;
    assign rsp.count     = count_reg;

    logic [CAPACITY:0] vld_vec;

    always_comb
    begin
        for (int j = 0; j <= CAPACITY; j++)
        begin
            vld_vec[j] = vld_chain[j];
        end
    end

    a_fill_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg == FILL_W'($countones(used_vec)))
        else $error("element count differs from occupied cells");

    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(CAPACITY))
        else $error("element count above capacity");

    a_single_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(vld_vec))
        else $error("more than one token in the cell row");

    a_accept_launches: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (launch_reg && state_reg == ST_SCAN))
        else $error("accepted request did not enter the cell row");

endmodule
